/* hdl/mode_speed_pid_motor_drive_macros.svh */
// Assertion macros for the speed controller
`ifndef MODE_SPEED_PID_MOTOR_DRIVE_MACROS_SVH
`define MODE_SPEED_PID_MOTOR_DRIVE_MACROS_SVH
`ifndef ASSERT_OFF
`define MSPD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MSPD_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSPD_ASSERT(label, clk, rstn, prop, msg)
`define MSPD_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* hdl/mspd_pkg.sv */
// Types and constants for the speed controller
`timescale 1ns / 1ps
package mspd_pkg;
    localparam logic [3:0] MOT_STOP     = 4'd0;
    localparam logic [3:0] MOT_SEND     = 4'd1;
    localparam logic [3:0] MOT_HOLD     = 4'd2;
    localparam logic [3:0] MOT_OVER     = 4'd3;
    localparam logic [3:0] MOT_PREPULL  = 4'd4;
    localparam logic [3:0] MOT_PULL     = 4'd5;
    localparam logic [3:0] MOT_ONUSE    = 4'd6;
    localparam logic [3:0] MOT_HALLPULL = 4'd7;
    localparam logic [3:0] MOT_BRAKE    = 4'd8;

    localparam logic [1:0] REG_KP     = 2'd0;
    localparam logic [1:0] REG_KI     = 2'd1;
    localparam logic [1:0] REG_KD     = 2'd2;
    localparam logic [1:0] REG_OFFSET = 2'd3;

    localparam logic [1:0] DM_FREE = 2'd0;
    localparam logic [1:0] DM_CW   = 2'd1;
    localparam logic [1:0] DM_CCW  = 2'd2;

    localparam logic [1:0] ONL_OFF = 2'd0;
    localparam logic [1:0] ONL_ONE = 2'd1;

    localparam int unsigned STALL_DRIVE = 820;
    localparam logic [31:0] STALL_MS    = 32'd2000;
    localparam logic signed [33:0] SPEED_STILL = 34'sd13107;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_INT   = 11'b00000000010,
        ST_DIVI  = 11'b00000000100,
        ST_ACC   = 11'b00000001000,
        ST_WIND  = 11'b00000010000,
        ST_ITRM  = 11'b00000100000,
        ST_DDIV  = 11'b00001000000,
        ST_SUM   = 11'b00010000000,
        ST_MUL   = 11'b00100000000,
        ST_OUT   = 11'b01000000000,
        ST_DONE  = 11'b10000000000
    } mspd_state_t;

    typedef struct packed {
        logic        start;
        logic        busy;
        logic        done;
    } mspd_div_ctl_t;
endpackage

/* hdl/mspd_div.sv */
// Iterative signed divider, truncating toward zero, one quotient bit per cycle
`timescale 1ns / 1ps
module mspd_div
    import mspd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [79:0] dividend,
    input  logic        [47:0] divisor,
    output mspd_div_ctl_t      ctl,
    output logic signed [79:0] quotient
);
    logic [79:0] q_reg, q_next;
    logic [48:0] r_reg, r_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [47:0] d_reg, d_next;
    logic [48:0] trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        d_next = d_reg;
        trial = {r_reg[47:0], q_reg[79]} - {1'b0, d_reg};
        if (start) begin
            neg_next = dividend[79];
            q_next = dividend[79] ? 80'(-dividend) : dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 7'd80;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[48]) begin
                r_next = trial;
                q_next = {q_reg[78:0], 1'b1};
            end else begin
                r_next = {r_reg[47:0], q_reg[79]};
                q_next = {q_reg[78:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        neg_reg <= neg_next;
        d_reg <= d_next;
    end

    assign ctl.start = start;
    assign ctl.busy = busy_reg;
    assign ctl.done = done_reg;
    assign quotient = neg_reg ? 80'(-$signed(q_reg)) : $signed(q_reg);
endmodule

/* hdl/mode_speed_pid_motor_drive.sv */
// Top level of the mode-selected PID speed controller with dead-zone offset
`timescale 1ns / 1ps
`include "mode_speed_pid_motor_drive_macros.svh"
// A tick that runs the regulator goes through the sequencer steps in order once
// the input beat is taken: a four-step reciprocal division by 1000 for the
// integral step, the anti-windup test, the bit-serial divider for the
// derivative term, the sum, the gain multiply and the output stage. With zero
// elapsed time the divide is skipped; stop and brake answer on the next cycle.
// Ready is low while a tick is in work and while a result waits in the output
// register to be taken.
module mode_speed_pid_motor_drive
    import mspd_pkg::*;
#(
    parameter int DRIVE_LIMIT = 880
)(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd_valid,
    input  logic [3:0]         s_cmd_motion,
    input  logic [15:0]        s_cmd_duration_ms,
    input  logic [31:0]        s_time_now_ms,
    input  logic signed [31:0] s_measured_speed,
    input  logic [22:0]        s_hall_pressure,
    input  logic [17:0]        s_pull_voltage,
    input  logic               s_pull_very_low,
    input  logic [1:0]         s_online_state,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [10:0] m_drive_value,
    output logic [1:0]         m_drive_mode,
    output logic [3:0]         m_active_motion
);
    localparam logic signed [63:0] LIM = 64'(DRIVE_LIMIT) <<< 24;
    localparam logic signed [63:0] SUM_CLAMP = 64'sd1 <<< 46;
    localparam logic signed [63:0] FIVE = 64'sd5 <<< 24;
    localparam logic [26:0] RECIP_1K = 27'd68719477;

    logic [15:0] kp_reg, ki_reg, kd_reg;
    logic [9:0]  offset_reg;
    logic signed [31:0] integ_reg, perr_reg;
    logic [3:0]  motion_reg;
    logic [31:0] mdl_reg, ptime_reg, sdl_reg;
    mspd_state_t state_reg;
    logic        out_valid_reg;
    logic signed [10:0] drv_reg;
    logic [1:0]  mode_reg;
    logic [3:0]  amot_reg;

    logic signed [31:0] speed_reg, e_reg;
    logic [31:0] now_reg, dt_reg;
    logic [1:0]  onl_reg;
    logic signed [63:0] iterm_reg;
    logic signed [63:0] dterm_reg;

    logic [63:0] mag_reg;
    logic        eneg_reg;
    logic [63:0] quot_reg;
    logic [9:0]  rem_reg;
    logic [1:0]  dig_reg;
    logic signed [31:0] cand_reg;
    logic signed [63:0] sumc_reg, o1_reg;

    logic        div_start;
    logic signed [79:0] div_dividend;
    logic [47:0] div_divisor;
    mspd_div_ctl_t div_ctl;
    logic signed [79:0] div_q;

    mspd_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_dividend), .divisor(div_divisor),
        .ctl(div_ctl), .quotient(div_q)
    );

    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        if (v > 80'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -80'sh80000000) return -32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] clamp(input logic signed [79:0] v,
                                                 input logic signed [63:0] l);
        if (v > 80'(l)) return l;
        if (v < -80'(l)) return -l;
        return v[63:0];
    endfunction

    function automatic logic later(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d != 0 && !d[31];
    endfunction

    // front end: motion update and target
    logic [3:0]  mot_new;
    logic [31:0] mdl_new;
    logic signed [39:0] tgt;
    logic signed [39:0] hall_s;
    logic signed [39:0] t4;
    always_comb begin
        mot_new = motion_reg;
        mdl_new = mdl_reg;
        if (s_cmd_valid) begin
            mot_new = s_cmd_motion;
            mdl_new = s_time_now_ms + 32'(s_cmd_duration_ms);
        end
        if (!later(mdl_new, s_time_now_ms)) mot_new = MOT_STOP;
        hall_s = 40'(s_hall_pressure);
        tgt = '0;
        t4 = '0;
        case (mot_new)
            MOT_SEND: tgt = 40'sd40 <<< 16;
            MOT_HOLD, MOT_OVER: begin
                tgt = (40'sd80 <<< 16) - hall_s;
                if (tgt < 0 && tgt > -(40'sd5 <<< 16)) tgt = '0;
            end
            MOT_PREPULL: begin
                t4 = ((40'sd30 <<< 16) - hall_s) * 3;
                tgt = t4 / 4;
                if (tgt > 0 && tgt < (40'sd5 <<< 16)) tgt = '0;
            end
            MOT_PULL: tgt = -(40'sd60 <<< 16);
            MOT_ONUSE: begin
                t4 = ((40'sd70 <<< 16) - hall_s) * 3;
                tgt = t4 / 4;
                if (tgt < 0 && tgt > -(40'sd5 <<< 16)) tgt = '0;
            end
            MOT_HALLPULL: begin
                tgt = 40'(s_pull_voltage) * 150 - (40'sd285 <<< 16);
                if (tgt > 0) tgt = '0;
                if (s_pull_very_low && s_online_state == ONL_ONE)
                    tgt = -(40'sd10 <<< 16);
            end
            default: tgt = '0;
        endcase
    end

    logic accept_in;
    assign accept_in = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;

    // integral step: divide |e*dt| by 1000 one 16-bit digit at a time
    logic signed [63:0] edt;
    logic [25:0] rv;
    logic [52:0] rprod;
    logic [15:0] rq;
    logic [9:0]  rr;
    logic signed [63:0] iq;
    always_comb begin
        edt = 64'(e_reg) * $signed({32'd0, dt_reg});
        rv = {rem_reg, mag_reg[63:48]};
        rprod = 53'(rv) * 53'(RECIP_1K);
        rq = rprod[51:36];
        rr = 10'(rv - 26'(rq) * 26'd1000);
        iq = eneg_reg ? -$signed(quot_reg) : $signed(quot_reg);
    end

    logic signed [63:0] kprod;
    logic signed [63:0] kmag;
    logic signed [79:0] sum80;
    logic signed [63:0] sumc;
    logic signed [79:0] o80;
    logic signed [63:0] o1, o2;
    logic [31:0] sdl_new;
    logic signed [63:0] drv64;
    logic signed [63:0] sl;
    always_comb begin
        kprod = $signed({48'd0, ki_reg}) * 64'(cand_reg);
        kmag = kprod < 0 ? -kprod : kprod;
        sum80 = 80'(e_reg) + 80'(iterm_reg) + 80'(dterm_reg);
        sumc = clamp(sum80, SUM_CLAMP);
        o80 = $signed({64'd0, kp_reg}) * 80'(sumc_reg);
        o1 = clamp(o80, LIM);
        if (o1_reg > FIVE) o2 = o1_reg + (64'(offset_reg) <<< 24);
        else if (o1_reg < -FIVE) o2 = o1_reg - (64'(offset_reg) <<< 24);
        else o2 = '0;
        o2 = clamp(80'(o2), LIM);
        sdl_new = sdl_reg;
        if (34'(speed_reg) > SPEED_STILL || 34'(speed_reg) < -SPEED_STILL
            || later(now_reg - STALL_MS, sdl_reg))
            sdl_new = now_reg + STALL_MS;
        sl = 64'(STALL_DRIVE) <<< 24;
        if (sdl_new != 0 && later(now_reg, sdl_new) && (o2 > sl || o2 < -sl)) o2 = '0;
        drv64 = (o2 + (o2[63] ? 64'sh00FF_FFFF : 64'sd0)) >>> 24;
    end

    always_comb begin
        div_start = (state_reg == ST_ITRM) && (dt_reg != 0);
        div_dividend = 80'($signed({64'd0, kd_reg}))
            * (80'(e_reg) - 80'(perr_reg)) * 80'sd1000;
        div_divisor = 48'(dt_reg) * 48'd256;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= 16'd384;
            ki_reg <= 16'd2560;
            kd_reg <= 16'd0;
            offset_reg <= 10'd380;
            integ_reg <= '0;
            perr_reg <= '0;
            motion_reg <= MOT_STOP;
            mdl_reg <= '0;
            ptime_reg <= '0;
            sdl_reg <= '0;
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_KP: kp_reg <= cfg_data;
                    REG_KI: ki_reg <= cfg_data;
                    REG_KD: kd_reg <= cfg_data;
                    REG_OFFSET: offset_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (accept_in) begin
                    motion_reg <= mot_new;
                    mdl_reg <= mdl_new;
                    amot_reg <= mot_new;
                    onl_reg <= s_online_state;
                    now_reg <= s_time_now_ms;
                    speed_reg <= s_measured_speed;
                    dt_reg <= s_time_now_ms - ptime_reg;
                    e_reg <= sat32(80'(tgt) - 80'(s_measured_speed));
                    if (mot_new == MOT_STOP || mot_new == MOT_BRAKE) begin
                        integ_reg <= '0;
                        perr_reg <= '0;
                        ptime_reg <= s_time_now_ms;
                        drv_reg <= '0;
                        mode_reg <= DM_FREE;
                        out_valid_reg <= 1'b1;
                    end else begin
                        state_reg <= ST_INT;
                    end
                end
                ST_INT: begin
                    mag_reg <= edt[63] ? 64'(-edt) : 64'(edt);
                    eneg_reg <= edt[63];
                    quot_reg <= '0;
                    rem_reg <= '0;
                    dig_reg <= '0;
                    state_reg <= ST_DIVI;
                end
                ST_DIVI: begin
                    quot_reg <= {quot_reg[47:0], rq};
                    rem_reg <= rr;
                    mag_reg <= {mag_reg[47:0], 16'd0};
                    dig_reg <= dig_reg + 2'd1;
                    if (dig_reg == 2'd3) state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    cand_reg <= sat32(80'(integ_reg) + 80'(iq));
                    state_reg <= ST_WIND;
                end
                ST_WIND: begin
                    if (2 * kmag < LIM) integ_reg <= cand_reg;
                    state_reg <= ST_ITRM;
                end
                ST_ITRM: begin
                    iterm_reg <= ($signed({48'd0, ki_reg}) * 64'(integ_reg)) / 256;
                    dterm_reg <= '0;
                    state_reg <= (dt_reg != 0) ? ST_DDIV : ST_SUM;
                end
                ST_DDIV: if (div_ctl.done) begin
                    dterm_reg <= div_q[63:0];
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    sumc_reg <= sumc;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    o1_reg <= o1;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    sdl_reg <= sdl_new;
                    drv_reg <= drv64[10:0];
                    mode_reg <= (onl_reg == ONL_OFF || drv64 == 0) ? DM_FREE
                              : (drv64 > 0 ? DM_CW : DM_CCW);
                    perr_reg <= e_reg;
                    ptime_reg <= now_reg;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_drive_value = drv_reg;
    assign m_drive_mode = mode_reg;
    assign m_active_motion = amot_reg;

    `MSPD_ASSERT(a_ready_idle, aclk, aresetn, s_ready |-> state_reg == ST_IDLE, "ready while busy")
    `MSPD_ASSERT(a_mode_free, aclk, aresetn, m_valid && m_drive_value == 0 |-> m_drive_mode == DM_FREE, "nonzero mode on zero drive")
    `MSPD_ASSERT(a_busy_nord, aclk, aresetn, div_ctl.busy |-> !s_ready, "ready during divide")
    `MSPD_ASSERT_RST(a_rst, aclk, !aresetn |=> !m_valid, "valid after reset")
endmodule

/* sim/mode_speed_pid_motor_drive_tb.sv */
// Self-checking testbench for the mode-selected PID speed controller
`timescale 1ns / 1ps
module mode_speed_pid_motor_drive_tb;
    import mspd_pkg::*;

    localparam int LIMIT = 880;
    localparam longint ONE = 65536;
    localparam int WATCHDOG = 20000;
    localparam int LONG_HOLD = 600;

    typedef struct {
        logic        cmd_valid;
        logic [3:0]  cmd_motion;
        logic [15:0] cmd_duration_ms;
        logic [31:0] time_now_ms;
        logic signed [31:0] measured_speed;
        logic [22:0] hall_pressure;
        logic [17:0] pull_voltage;
        logic        pull_very_low;
        logic [1:0]  online_state;
    } tick_t;

    typedef struct {
        logic [10:0] drive_value;
        logic [1:0]  drive_mode;
        logic [3:0]  active_motion;
    } drive_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_KP;
    logic [15:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_cmd_valid = 1'b0;
    logic [3:0] s_cmd_motion = MOT_STOP;
    logic [15:0] s_cmd_duration_ms = '0;
    logic [31:0] s_time_now_ms = '0;
    logic signed [31:0] s_measured_speed = '0;
    logic [22:0] s_hall_pressure = '0;
    logic [17:0] s_pull_voltage = '0;
    logic s_pull_very_low = 1'b0;
    logic [1:0] s_online_state = ONL_OFF;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [10:0] m_drive_value;
    logic [1:0] m_drive_mode;
    logic [3:0] m_active_motion;

    mode_speed_pid_motor_drive #(.DRIVE_LIMIT(LIMIT)) dut (.*);

    always #5 aclk = ~aclk;

    // controller copy
    longint gain_p, gain_i, gain_d, dz_offset;
    logic signed [31:0] int_acc, last_err;
    logic [3:0] motion_now;
    logic [31:0] motion_end, last_ms, stall_end;

    drive_t expected_drives[$];
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    logic hold_kick = 1'b0;
    int mismatches = 0;
    int ticks_sent = 0;
    int drives_seen = 0;
    int cfg_writes = 0;
    logic [31:0] clock_ms = 32'd100;

    function automatic logic is_later(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d != 0 && d < 32'h8000_0000;
    endfunction

    function automatic longint clamp_to(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic signed [31:0] sat_q16(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic void reset_controller();
        gain_p = 384; gain_i = 2560; gain_d = 0; dz_offset = 380;
        int_acc = 0; last_err = 0; motion_now = MOT_STOP;
        motion_end = 0; last_ms = 0; stall_end = 0;
    endfunction

    function automatic drive_t compute_drive(tick_t t);
        drive_t r;
        longint spd, hall, pv, tgt, drv, prod, mag, iterm, dterm, sum, o, lim, five;
        logic [31:0] dt;
        logic signed [31:0] err, cand;
        spd = longint'(t.measured_speed);
        hall = longint'(t.hall_pressure);
        pv = longint'(t.pull_voltage);
        drv = 0;
        lim = longint'(LIMIT) <<< 24;
        five = 64'sd5 <<< 24;
        if (t.cmd_valid) begin
            motion_now = t.cmd_motion;
            motion_end = t.time_now_ms + 32'(t.cmd_duration_ms);
        end
        if (!is_later(motion_end, t.time_now_ms)) motion_now = MOT_STOP;
        if (motion_now == MOT_STOP || motion_now == MOT_BRAKE) begin
            int_acc = 0;
            last_err = 0;
            last_ms = t.time_now_ms;
        end else begin
            dt = t.time_now_ms - last_ms;
            case (motion_now)
                MOT_SEND: tgt = 40 * ONE;
                MOT_HOLD, MOT_OVER: begin
                    tgt = 80 * ONE - hall;
                    if (tgt < 0 && tgt > -5 * ONE) tgt = 0;
                end
                MOT_PREPULL: begin
                    tgt = (30 * ONE - hall) * 3 / 4;
                    if (tgt > 0 && tgt < 5 * ONE) tgt = 0;
                end
                MOT_PULL: tgt = -60 * ONE;
                MOT_ONUSE: begin
                    tgt = (70 * ONE - hall) * 3 / 4;
                    if (tgt < 0 && tgt > -5 * ONE) tgt = 0;
                end
                MOT_HALLPULL: begin
                    tgt = pv * 150 - 285 * ONE;
                    if (tgt > 0) tgt = 0;
                    if (t.pull_very_low && t.online_state == ONL_ONE) tgt = -10 * ONE;
                end
                default: tgt = 0;
            endcase
            err = sat_q16(tgt - spd);
            cand = sat_q16(longint'(int_acc) + (longint'(err) * longint'(dt)) / 1000);
            prod = gain_i * longint'(cand);
            mag = prod < 0 ? -prod : prod;
            if (2 * mag < lim) int_acc = cand;
            iterm = (gain_i * longint'(int_acc)) / 256;
            dterm = 0;
            if (dt != 0)
                dterm = (gain_d * (longint'(err) - longint'(last_err)) * 1000)
                        / (longint'(dt) * 256);
            sum = clamp_to(longint'(err) + iterm + dterm, 64'sd1 <<< 46);
            o = clamp_to(gain_p * sum, lim);
            if (o > five) o = o + (dz_offset <<< 24);
            else if (o < -five) o = o - (dz_offset <<< 24);
            else o = 0;
            o = clamp_to(o, lim);
            if (spd > 13107 || spd < -13107 || is_later(t.time_now_ms - STALL_MS, stall_end))
                stall_end = t.time_now_ms + STALL_MS;
            if (stall_end != 0 && is_later(t.time_now_ms, stall_end))
                if (o > (longint'(STALL_DRIVE) <<< 24) || o < -(longint'(STALL_DRIVE) <<< 24))
                    o = 0;
            drv = o / (64'sd1 <<< 24);
            last_err = err;
            last_ms = t.time_now_ms;
        end
        r.drive_value = drv[10:0];
        r.drive_mode = (t.online_state == ONL_OFF || drv == 0) ? DM_FREE
                     : (drv > 0 ? DM_CW : DM_CCW);
        r.active_motion = motion_now;
        return r;
    endfunction

    // result side: random or long stalls
    int hold_left = 0;
    logic kick_seen = 1'b0;
    always @(posedge aclk) begin
        if (hold_kick != kick_seen) begin
            kick_seen <= hold_kick;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge aclk) begin
        drive_t want;
        if (aresetn && m_valid && m_ready) begin
            drives_seen++;
            if (expected_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: drive %0d", m_drive_value);
            end else begin
                want = expected_drives.pop_front();
                if (m_drive_value !== want.drive_value || m_drive_mode !== want.drive_mode ||
                    m_active_motion !== want.active_motion) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: drive %0d/%0d mode %0d/%0d motion %0d/%0d",
                                 $signed(want.drive_value), m_drive_value, want.drive_mode,
                                 m_drive_mode, want.active_motion, m_active_motion);
                end
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_tick(tick_t t);
        int gap;
        if ($urandom_range(99) < src_idle_pct) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd_valid <= t.cmd_valid;
        s_cmd_motion <= t.cmd_motion;
        s_cmd_duration_ms <= t.cmd_duration_ms;
        s_time_now_ms <= t.time_now_ms;
        s_measured_speed <= t.measured_speed;
        s_hall_pressure <= t.hall_pressure;
        s_pull_voltage <= t.pull_voltage;
        s_pull_very_low <= t.pull_very_low;
        s_online_state <= t.online_state;
        do @(posedge aclk); while (!s_ready);
        expected_drives.push_back(compute_drive(t));
        ticks_sent++;
    endtask

    task automatic drain_drives();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_drives.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            REG_KP: gain_p = longint'(val);
            REG_KI: gain_i = longint'(val);
            REG_KD: gain_d = longint'(val);
            default: dz_offset = longint'(val & 16'h03FF);
        endcase
        cfg_writes++;
    endtask

    task automatic set_gains(logic [15:0] p, logic [15:0] i, logic [15:0] d, logic [15:0] off);
        drain_drives();
        write_reg(REG_KP, p);
        write_reg(REG_KI, i);
        write_reg(REG_KD, d);
        write_reg(REG_OFFSET, off);
        cfg_we <= 1'b0;
    endtask

    function automatic tick_t plain_tick(logic [3:0] mot, logic cmd, logic [15:0] dur,
                                         logic [31:0] ms, logic signed [31:0] spd);
        tick_t t;
        t.cmd_valid = cmd; t.cmd_motion = mot; t.cmd_duration_ms = dur;
        t.time_now_ms = ms; t.measured_speed = spd;
        t.hall_pressure = 23'(50 * ONE); t.pull_voltage = 18'(2 * ONE);
        t.pull_very_low = 1'b0; t.online_state = 2'd2;
        return t;
    endfunction

    task automatic random_tick(output tick_t t);
        if ($urandom_range(99) < 12) begin
            t.cmd_valid = 1'($urandom_range(1)); t.cmd_motion = 4'($urandom_range(15));
            t.cmd_duration_ms = 16'($urandom); t.time_now_ms = $urandom;
            t.measured_speed = $urandom; t.hall_pressure = 23'($urandom);
            t.pull_voltage = 18'($urandom); t.pull_very_low = 1'($urandom_range(1));
            t.online_state = 2'($urandom_range(3));
            clock_ms = t.time_now_ms;
        end else begin
            clock_ms = clock_ms + ($urandom_range(99) < 3 ? $urandom_range(0, 3000)
                                                         : $urandom_range(0, 40));
            t.cmd_valid = ($urandom_range(99) < 10);
            t.cmd_motion = ($urandom_range(99) < 95) ? 4'($urandom_range(8))
                                                     : 4'($urandom_range(15));
            t.cmd_duration_ms = ($urandom_range(9) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 4000));
            t.time_now_ms = clock_ms;
            t.measured_speed = $signed($urandom_range(0, 240 * 65536)) - 120 * 65536;
            t.hall_pressure = 23'($urandom_range(0, 6553600));
            t.pull_voltage = 18'($urandom_range(0, 216269));
            t.pull_very_low = 1'($urandom_range(1));
            t.online_state = 2'($urandom_range(3));
        end
    endtask

    task automatic test_directed();
        logic [31:0] ms;
        ms = 32'd1000;
        for (int m = 0; m < 16; m++) begin
            ms += 10;
            send_tick(plain_tick(4'(m), 1'b1, 16'd500, ms, (m % 2) ? 32'sh7FFF_FFFF
                                                                   : 32'sh8000_0000));
        end
        send_tick(plain_tick(MOT_SEND, 1'b1, 16'hFFFF, ms, 0));
        send_tick(plain_tick(MOT_SEND, 1'b0, 16'd0, ms, 0));
        ms += 2500;
        send_tick(plain_tick(MOT_SEND, 1'b0, 16'd0, ms, 0));
        ms += 2500;
        send_tick(plain_tick(MOT_SEND, 1'b0, 16'd0, ms, 0));
        send_tick(plain_tick(MOT_HALLPULL, 1'b1, 16'd0, ms, 0));
        begin
            tick_t t;
            t = plain_tick(MOT_HALLPULL, 1'b1, 16'd300, 32'hFFFF_FFF0, 32'sd1000);
            t.pull_very_low = 1'b1; t.online_state = ONL_ONE;
            t.hall_pressure = 23'h7F_FFFF; t.pull_voltage = 18'h3_FFFF;
            send_tick(t);
            t.time_now_ms = 32'h0000_0020; t.online_state = ONL_OFF;
            t.cmd_valid = 1'b0;
            send_tick(t);
            t.cmd_valid = 1'b1; t.cmd_motion = MOT_PREPULL; t.hall_pressure = '0;
            t.pull_voltage = '0; t.pull_very_low = 1'b0; t.online_state = 2'd3;
            send_tick(t);
        end
        clock_ms = 32'd100000;
    endtask

    task automatic test_random(int count, int idle, int stall);
        tick_t t;
        src_idle_pct = idle;
        snk_stall_pct = stall;
        repeat (count) begin
            random_tick(t);
            send_tick(t);
        end
    endtask

    task automatic test_long_hold();
        tick_t t;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_kick <= ~hold_kick;
        repeat (40) begin
            random_tick(t);
            send_tick(t);
        end
    endtask

    task automatic test_pause();
        tick_t t;
        repeat (6) begin
            drain_drives();
            repeat (5) begin
                random_tick(t);
                send_tick(t);
            end
        end
    endtask

    initial begin
        reset_controller();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        set_gains(16'd384, 16'd2560, 16'd0, 16'd380);
        test_random(360, 0, 0);
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd880);
        test_random(360, 60, 0);
        set_gains(16'd0, 16'd0, 16'd0, 16'd0);
        test_random(120, 0, 60);
        set_gains(16'd600, 16'd1200, 16'd300, 16'd200);
        test_random(240, 0, 60);
        set_gains(16'd256, 16'd40, 16'd5000, 16'd500);
        test_random(350, 25, 25);
        test_long_hold();
        test_pause();
        drain_drives();
        repeat (400) @(posedge aclk);
        $display("covered %0d ticks, %0d drive beats, %0d register writes, all motion codes,",
                 ticks_sent, drives_seen, cfg_writes);
        $display("gain extremes, time wrap, stall guard, long output stall, mismatches %0d",
                 mismatches);
        if (mismatches == 0 && expected_drives.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

/* mode_speed_pid_motor_drive.f */
+incdir+hdl
hdl/mspd_pkg.sv
hdl/mspd_div.sv
hdl/mode_speed_pid_motor_drive.sv
sim/mode_speed_pid_motor_drive_tb.sv
